// File: src/rc4sc_pkg.sv
// Shared types, constants and the control store of the RC4 cipher core.
// Used by the sequencer, the datapath and the top level; depends on nothing.
`default_nettype none

package rc4sc_pkg;

  localparam int DATA_W          = 8;
  localparam int PERM_DEPTH      = 256;
  localparam int KEY_DEPTH_DEF   = 256;
  localparam int KEY_LEN_W       = 9;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

  // Commands carried in tuser of the input channel.
  localparam logic [1:0] CMD_KEY   = 2'd0;
  localparam logic [1:0] CMD_SCHED = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;

  // Result kinds carried in tuser of the output channel.
  localparam logic [1:0] KIND_DONE   = 2'd0;
  localparam logic [1:0] KIND_CIPHER = 2'd1;
  localparam logic [1:0] KIND_ECHO   = 2'd2;

  // Program steps.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] ST_KEYWR = 4'd1;
  localparam logic [STEP_W-1:0] ST_SCLR  = 4'd2;
  localparam logic [STEP_W-1:0] ST_SFILL = 4'd3;
  localparam logic [STEP_W-1:0] ST_SK1   = 4'd4;
  localparam logic [STEP_W-1:0] ST_SK2   = 4'd5;
  localparam logic [STEP_W-1:0] ST_SK3   = 4'd6;
  localparam logic [STEP_W-1:0] ST_SK4   = 4'd7;
  localparam logic [STEP_W-1:0] ST_SDONE = 4'd8;
  localparam logic [STEP_W-1:0] ST_DATA  = 4'd9;
  localparam logic [STEP_W-1:0] ST_D0    = 4'd10;
  localparam logic [STEP_W-1:0] ST_D1    = 4'd11;
  localparam logic [STEP_W-1:0] ST_D2    = 4'd12;
  localparam logic [STEP_W-1:0] ST_D3    = 4'd13;
  localparam logic [STEP_W-1:0] ST_ECHO  = 4'd14;

  // Jump conditions.
  localparam logic [2:0] JC_SEQ      = 3'd0;
  localparam logic [2:0] JC_ALWAYS   = 3'd1;
  localparam logic [2:0] JC_DISPATCH = 3'd2;
  localparam logic [2:0] JC_LOOP     = 3'd3;  // jump while n is not the last index
  localparam logic [2:0] JC_UNKEYED  = 3'd4;

  // Permutation read address select.
  localparam logic [2:0] RA_NONE = 3'd0;
  localparam logic [2:0] RA_N    = 3'd1;
  localparam logic [2:0] RA_IINC = 3'd2;
  localparam logic [2:0] RA_JKEY = 3'd3;
  localparam logic [2:0] RA_JSUM = 3'd4;
  localparam logic [2:0] RA_T    = 3'd5;

  // Permutation write select: address and data.
  localparam logic [2:0] WR_NONE = 3'd0;
  localparam logic [2:0] WR_N_N  = 3'd1;
  localparam logic [2:0] WR_N_RD = 3'd2;
  localparam logic [2:0] WR_J_A  = 3'd3;
  localparam logic [2:0] WR_I_RD = 3'd4;

  localparam logic [1:0] J_HOLD    = 2'd0;
  localparam logic [1:0] J_CLR     = 2'd1;
  localparam logic [1:0] J_SUM     = 2'd2;
  localparam logic [1:0] J_SUM_KEY = 2'd3;

  localparam logic [1:0] N_HOLD  = 2'd0;
  localparam logic [1:0] N_CLR   = 2'd1;
  localparam logic [1:0] N_INC   = 2'd2;
  localparam logic [1:0] N_INC_K = 2'd3;

  localparam logic [1:0] EM_NONE   = 2'd0;
  localparam logic [1:0] EM_DONE   = 2'd1;
  localparam logic [1:0] EM_CIPHER = 2'd2;
  localparam logic [1:0] EM_ECHO   = 2'd3;

  typedef struct packed {
    logic [STEP_W-1:0] target;
    logic [2:0]        jc;
    logic [2:0]        ra;
    logic [2:0]        wr;
    logic              k_re;
    logic              k_we;
    logic [1:0]        j_op;
    logic [1:0]        n_op;
    logic              a_ld;
    logic              bt_ld;
    logic              i_inc;
    logic [1:0]        em;
    logic              set_keyed;
  } ctrl_t;

  typedef struct packed {
    logic n_last;
    logic keyed;
    logic stall;
  } stat_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] pc);
    ctrl_t c;
    c = '0;
    case (pc)
      ST_IDLE: begin
        c.jc = JC_DISPATCH;
      end
      ST_KEYWR: begin
        c.k_we   = 1'b1;
        c.jc     = JC_ALWAYS;
        c.target = ST_IDLE;
      end
      ST_SCLR: begin
        c.n_op = N_CLR;
        c.j_op = J_CLR;
      end
      ST_SFILL: begin
        c.wr     = WR_N_N;
        c.n_op   = N_INC;
        c.jc     = JC_LOOP;
        c.target = ST_SFILL;
      end
      ST_SK1: begin
        c.ra   = RA_N;
        c.k_re = 1'b1;
      end
      ST_SK2: begin
        c.a_ld = 1'b1;
        c.j_op = J_SUM_KEY;
        c.ra   = RA_JKEY;
      end
      ST_SK3: begin
        c.wr = WR_N_RD;
      end
      ST_SK4: begin
        c.wr     = WR_J_A;
        c.n_op   = N_INC_K;
        c.jc     = JC_LOOP;
        c.target = ST_SK1;
      end
      ST_SDONE: begin
        c.em        = EM_DONE;
        c.set_keyed = 1'b1;
        c.j_op      = J_CLR;
        c.jc        = JC_ALWAYS;
        c.target    = ST_IDLE;
      end
      ST_DATA: begin
        c.jc     = JC_UNKEYED;
        c.target = ST_ECHO;
      end
      ST_D0: begin
        c.i_inc = 1'b1;
        c.ra    = RA_IINC;
      end
      ST_D1: begin
        c.a_ld = 1'b1;
        c.j_op = J_SUM;
        c.ra   = RA_JSUM;
      end
      ST_D2: begin
        c.bt_ld = 1'b1;
        c.wr    = WR_I_RD;
        c.ra    = RA_T;
      end
      ST_D3: begin
        c.wr     = WR_J_A;
        c.em     = EM_CIPHER;
        c.jc     = JC_ALWAYS;
        c.target = ST_IDLE;
      end
      ST_ECHO: begin
        c.em     = EM_ECHO;
        c.jc     = JC_ALWAYS;
        c.target = ST_IDLE;
      end
      default: begin
        c.jc     = JC_ALWAYS;
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/rc4sc_ram.sv
// Generic memory with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module rc4sc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/rc4sc_seq.sv
// Step counter and control store lookup of the RC4 core.
// Depends on rc4sc_pkg for the program and the control word type.
`default_nettype none

module rc4sc_seq import rc4sc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [1:0] command,
  input  wire stat_t      stat,
  output logic            idle,
  output ctrl_t           ctrl
);

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;

  assign ctrl = ucode(pc);
  assign idle = (pc == ST_IDLE);

  always_comb begin
    pc_next = pc;
    if (!stat.stall) begin
      case (ctrl.jc)
        JC_SEQ:    pc_next = pc + 1'b1;
        JC_ALWAYS: pc_next = ctrl.target;
        JC_DISPATCH: begin
          pc_next = ST_IDLE;
          if (accept) begin
            case (command)
              CMD_KEY:   pc_next = ST_KEYWR;
              CMD_SCHED: pc_next = ST_SCLR;
              CMD_DATA:  pc_next = ST_DATA;
              default:   pc_next = ST_IDLE;
            endcase
          end
        end
        JC_LOOP:    pc_next = stat.n_last ? pc + 1'b1 : ctrl.target;
        JC_UNKEYED: pc_next = stat.keyed ? pc + 1'b1 : ctrl.target;
        default:    pc_next = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

// File: src/rc4sc_dp.sv
// Datapath of the RC4 core: indices, permutation and key memories, output register.
// Depends on rc4sc_pkg and rc4sc_ram; driven by the control word of rc4sc_seq.
`default_nettype none

module rc4sc_dp import rc4sc_pkg::*; #(
  parameter int KEY_STORE_DEPTH = KEY_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ctrl_t                ctrl,
  output stat_t                     stat,
  input  wire logic                 accept,
  input  wire logic [DATA_W-1:0]    in_key_index,
  input  wire logic [DATA_W-1:0]    in_value,
  input  wire logic                 cfg_we,
  input  wire logic [KEY_LEN_W-1:0] cfg_wdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [DATA_W-1:0]         m_tdata,
  output logic [1:0]                m_tuser
);

  localparam int KAW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
  localparam logic [KEY_LEN_W-1:0] DEPTH_LEN = KEY_LEN_W'(KEY_STORE_DEPTH);

  logic [KEY_LEN_W-1:0] key_len;
  logic [KEY_LEN_W-1:0] len_eff;
  logic [DATA_W-1:0]    key_index_q;
  logic [DATA_W-1:0]    value_q;
  logic [DATA_W-1:0]    idx_i;
  logic [DATA_W-1:0]    idx_j;
  logic [DATA_W-1:0]    n;
  logic [KAW-1:0]       kn;
  logic [DATA_W-1:0]    a;
  logic [DATA_W-1:0]    b;
  logic [DATA_W-1:0]    t;
  logic                 keyed;
  logic                 en;

  logic [DATA_W-1:0] s_rd;
  logic [DATA_W-1:0] k_rd;
  logic [DATA_W-1:0] s_raddr;
  logic [DATA_W-1:0] s_waddr;
  logic [DATA_W-1:0] s_wdata;
  logic              s_we;
  logic              s_re;
  logic [DATA_W-1:0] i_inc;
  logic [DATA_W-1:0] j_sum;
  logic [DATA_W-1:0] j_sum_k;
  logic [DATA_W-1:0] t_sum;
  logic [DATA_W-1:0] ks;
  logic              key_ok;

  assign stat.stall  = (ctrl.em != EM_NONE) && m_tvalid && !m_tready;
  assign stat.n_last = (n == '1);
  assign stat.keyed  = keyed;
  assign en          = !stat.stall;

  always_comb begin
    if (key_len == '0) begin
      len_eff = KEY_LEN_W'(1);
    end else if (key_len > DEPTH_LEN) begin
      len_eff = DEPTH_LEN;
    end else begin
      len_eff = key_len;
    end
  end

  assign i_inc   = idx_i + 1'b1;
  assign j_sum   = idx_j + s_rd;
  assign j_sum_k = idx_j + s_rd + k_rd;
  assign t_sum   = a + s_rd;

  always_comb begin
    s_re    = 1'b1;
    s_raddr = n;
    case (ctrl.ra)
      RA_N:    s_raddr = n;
      RA_IINC: s_raddr = i_inc;
      RA_JKEY: s_raddr = j_sum_k;
      RA_JSUM: s_raddr = j_sum;
      RA_T:    s_raddr = t_sum;
      default: s_re = 1'b0;
    endcase
  end

  always_comb begin
    s_we    = en;
    s_waddr = n;
    s_wdata = n;
    case (ctrl.wr)
      WR_N_N: begin
        s_waddr = n;
        s_wdata = n;
      end
      WR_N_RD: begin
        s_waddr = n;
        s_wdata = s_rd;
      end
      WR_J_A: begin
        s_waddr = idx_j;
        s_wdata = a;
      end
      WR_I_RD: begin
        s_waddr = idx_i;
        s_wdata = s_rd;
      end
      default: s_we = 1'b0;
    endcase
  end

  rc4sc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(PERM_DEPTH)
  ) u_perm (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .re   (s_re),
    .raddr(s_raddr),
    .rdata(s_rd)
  );

  assign key_ok = {1'b0, key_index_q} < DEPTH_LEN;

  rc4sc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(KEY_STORE_DEPTH)
  ) u_key (
    .clk  (clk),
    .we   (ctrl.k_we && key_ok),
    .waddr(key_index_q[KAW-1:0]),
    .wdata(value_q),
    .re   (ctrl.k_re),
    .raddr(kn),
    .rdata(k_rd)
  );

  // The last read of the swap went out before the two writes landed, so the
  // keystream byte is taken from the swapped values when it hits i or j.
  always_comb begin
    if (t == idx_i) begin
      ks = b;
    end else if (t == idx_j) begin
      ks = a;
    end else begin
      ks = s_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_index_q <= in_key_index;
      value_q     <= in_value;
    end
    if (en) begin
      if (ctrl.a_ld) begin
        a <= s_rd;
      end
      if (ctrl.bt_ld) begin
        b <= s_rd;
        t <= t_sum;
      end
      case (ctrl.n_op)
        N_CLR: begin
          n  <= '0;
          kn <= '0;
        end
        N_INC: n <= n + 1'b1;
        N_INC_K: begin
          n <= n + 1'b1;
          if (KEY_LEN_W'(kn) + 1'b1 == len_eff) begin
            kn <= '0;
          end else begin
            kn <= kn + 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (en && ctrl.em != EM_NONE) begin
      case (ctrl.em)
        EM_DONE: begin
          m_tdata <= '0;
          m_tuser <= KIND_DONE;
        end
        EM_CIPHER: begin
          m_tdata <= value_q ^ ks;
          m_tuser <= KIND_CIPHER;
        end
        default: begin
          m_tdata <= value_q;
          m_tuser <= KIND_ECHO;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_len  <= KEY_LEN_RESET;
      idx_i    <= '0;
      idx_j    <= '0;
      keyed    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_len <= cfg_wdata;
      end
      if (en) begin
        if (ctrl.i_inc) begin
          idx_i <= i_inc;
        end
        case (ctrl.j_op)
          J_CLR:     idx_j <= '0;
          J_SUM:     idx_j <= j_sum;
          J_SUM_KEY: idx_j <= j_sum_k;
          default:   ;
        endcase
        if (ctrl.set_keyed) begin
          keyed <= 1'b1;
          idx_i <= '0;
        end
      end
      if (en && ctrl.em != EM_NONE) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_emit_fills_output: assert property (@(posedge clk) disable iff (rst)
    en && ctrl.em != EM_NONE |=> m_tvalid)
    else $error("emitted result did not reach the output register");

  a_cipher_needs_key: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_CIPHER |-> keyed)
    else $error("cipher byte produced without a key schedule");

  a_keyed_with_done: assert property (@(posedge clk) disable iff (rst)
    $rose(keyed) |-> m_tvalid && m_tuser == KIND_DONE && idx_i == '0 && idx_j == '0)
    else $error("schedule completion not reported or indices not cleared");

endmodule

`default_nettype wire

// File: src/rc4_stream_cipher_core.sv
// Top level of the RC4 stream cipher core: input and output channels, configuration.
// Depends on rc4sc_pkg, rc4sc_seq, rc4sc_dp and rc4sc_ram.
//
// Input beats carry a command in s_tuser: write a key byte, run the key
// schedule, or encrypt/decrypt one data byte. Key bytes land in the key store
// at key_index. A schedule reads the key bytes at the front of the store, as
// many as the key length register gives (written through cfg_we/cfg_wdata,
// 16 after reset), and answers with one done beat.
// Each data beat answers with one cipher beat, or with the data echoed and
// flagged while no schedule has run. Key writes give no output beat.
// A small microprogram steps through every command; one permutation memory
// with one write and one read port sets the steps of each command:
//   key write   a key store write step, no result
//   data byte   a keyed check, then read, sum, swap and emit steps (an echo
//               step when not keyed); the result shows the cycle after the last step
//   schedule    256 fill steps plus 256 rounds of 4 steps
// One item is worked on at a time; s_tready is high only between items.
// The output beat sits in a register, so a new item is accepted while it
// waits; a stalled receiver only halts the program at its next result step.
// Reset clears the indices, the keyed flag and the output valid flag and sets
// the key length to 16; the memories keep their contents and need no clearing.
`default_nettype none

module rc4_stream_cipher_core import rc4sc_pkg::*; #(
  parameter int KEY_STORE_DEPTH = KEY_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [15:0]          s_tdata,   // key_index[7:0], value[15:8]
  input  wire logic [1:0]           s_tuser,   // command[1:0]
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [7:0]                m_tdata,   // out_byte[7:0]
  output logic [1:0]                m_tuser,   // kind[1:0]
  input  wire logic                 cfg_we,
  input  wire logic [KEY_LEN_W-1:0] cfg_wdata
);

  ctrl_t ctrl;
  stat_t stat;
  logic  idle;
  logic  accept;

  assign s_tready = idle && !rst;
  assign accept   = s_tvalid && s_tready;

  rc4sc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .command(s_tuser),
    .stat   (stat),
    .idle   (idle),
    .ctrl   (ctrl)
  );

  rc4sc_dp #(
    .KEY_STORE_DEPTH(KEY_STORE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .accept      (accept),
    .in_key_index(s_tdata[7:0]),
    .in_value    (s_tdata[15:8]),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

`default_nettype wire

// File: tb/rc4_stream_cipher_core_tb.sv
// Self-checking testbench for rc4_stream_cipher_core: drives key, schedule and data beats,
// predicts every result with its own RC4 model and checks the output stream field by field.
// Depends on rc4sc_pkg and the core RTL only.
`default_nettype none

module rc4_stream_cipher_core_tb;
  import rc4sc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 600;
  localparam int HOLD_CYCLES = 2500;
  localparam int CFG_GAP     = 16;    // lets a key write still in flight finish first
  localparam int END_GAP     = 1300;  // one full key schedule

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] kidx;
    logic [7:0] val;
  } beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
  } res_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata = '0;
  logic [1:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;
  logic [1:0]           m_tuser;
  logic                 cfg_we = 1'b0;
  logic [KEY_LEN_W-1:0] cfg_wdata = '0;

  // Cipher state as the block should hold it.
  logic [7:0]           sbox [256];
  logic [7:0]           ks_bytes [256];
  logic [7:0]           ptr_i = '0;
  logic [7:0]           ptr_j = '0;
  bit                   is_keyed = 1'b0;
  logic [KEY_LEN_W-1:0] sched_len = KEY_LEN_RESET;

  beat_t tx_items [$];
  res_t  cipher_expect [$];
  bit    key_set [256];
  int    item_count = 0;
  int    err_count = 0;
  int    tx_idle_pct = 0;
  int    rx_stall_pct = 0;
  int    hold_req = 0;
  int    hold_ack = 0;
  int    hold_left = 0;
  beat_t nxt;
  beat_t acc;
  res_t  pred;
  res_t  want;
  bit    got;

  rc4_stream_cipher_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic void rc4_predict(input beat_t b, output bit has_res, output res_t r);
    logic [7:0] i;
    logic [7:0] j;
    logic [7:0] t;
    int len;
    has_res = 1'b0;
    r = '0;
    case (b.cmd)
      CMD_KEY: begin
        ks_bytes[b.kidx] = b.val;
      end
      CMD_SCHED: begin
        len = int'(sched_len);
        if (len == 0) len = 1;
        if (len > 256) len = 256;
        for (int n = 0; n < 256; n++) sbox[n] = n[7:0];
        j = '0;
        for (int n = 0; n < 256; n++) begin
          j = j + sbox[n] + ks_bytes[n % len];
          t = sbox[n];
          sbox[n] = sbox[j];
          sbox[j] = t;
        end
        ptr_i = '0;
        ptr_j = '0;
        is_keyed = 1'b1;
        has_res = 1'b1;
        r.kind = KIND_DONE;
      end
      CMD_DATA: begin
        has_res = 1'b1;
        if (!is_keyed) begin
          r.out_byte = b.val;
          r.kind = KIND_ECHO;
        end else begin
          i = ptr_i + 8'd1;
          j = ptr_j + sbox[i];
          t = sbox[i];
          sbox[i] = sbox[j];
          sbox[j] = t;
          t = sbox[i] + sbox[j];
          ptr_i = i;
          ptr_j = j;
          r.out_byte = b.val ^ sbox[t];
          r.kind = KIND_CIPHER;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Sender: offers the next pending beat once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (tx_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = tx_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= nxt.cmd;
        s_tdata  <= {nxt.val, nxt.kidx};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started by a request from the stimulus process.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver and checker. The output beat is checked before the input beat of the
  // same edge is predicted, so the oldest expectation is always the one compared.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
      if (m_tvalid && m_tready) begin
        if (cipher_expect.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none actual byte %02h kind %0d",
                   $time, m_tdata, m_tuser);
        end else begin
          want = cipher_expect.pop_front();
          if (m_tdata !== want.out_byte) begin
            err_count++;
            $display("%0t: out_byte mismatch, expected %02h actual %02h",
                     $time, want.out_byte, m_tdata);
          end
          if (m_tuser !== want.kind) begin
            err_count++;
            $display("%0t: kind mismatch, expected %0d actual %0d", $time, want.kind, m_tuser);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        acc.cmd  = s_tuser;
        acc.kidx = s_tdata[7:0];
        acc.val  = s_tdata[15:8];
        rc4_predict(acc, got, pred);
        if (got) cipher_expect.push_back(pred);
      end
    end
  end

  task automatic push_beat(input logic [1:0] cmd, input logic [7:0] kidx,
                           input logic [7:0] val);
    beat_t b;
    b.cmd  = cmd;
    b.kidx = kidx;
    b.val  = val;
    tx_items.push_back(b);
    if (cmd == CMD_KEY) key_set[kidx] = 1'b1;
    if (cmd != CMD_UNUSED) item_count++;
  endtask

  // A schedule only ever reads key bytes that were written first.
  task automatic push_schedule();
    int len;
    len = int'(sched_len);
    if (len == 0) len = 1;
    if (len > 256) len = 256;
    for (int k = 0; k < len; k++)
      if (!key_set[k]) push_beat(CMD_KEY, k[7:0], 8'($urandom_range(0, 255)));
    push_beat(CMD_SCHED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    do @(negedge clk); while (tx_items.size() != 0 || s_tvalid);
    while (cipher_expect.size() != 0) @(negedge clk);
  endtask

  task automatic set_key_len(input logic [KEY_LEN_W-1:0] v);
    repeat (CFG_GAP) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    sched_len = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int round;
    int roll;
    logic [KEY_LEN_W-1:0] len_pick;
    round = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: unkeyed echo, the unused command, a key under the reset key length,
    // then cipher bytes at the data extremes.
    push_beat(CMD_DATA, 8'h00, 8'h00);
    push_beat(CMD_DATA, 8'hFF, 8'hFF);
    push_beat(CMD_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    push_beat(CMD_UNUSED, 8'hFF, 8'hFF);
    push_beat(CMD_KEY, 8'd0, 8'hFF);
    for (int k = 1; k < 15; k++) push_beat(CMD_KEY, k[7:0], 8'($urandom_range(0, 255)));
    push_beat(CMD_KEY, 8'd15, 8'h00);
    push_beat(CMD_KEY, 8'd255, 8'($urandom_range(0, 255)));
    push_schedule();
    push_beat(CMD_DATA, 8'h00, 8'h00);
    push_beat(CMD_DATA, 8'hFF, 8'hFF);
    push_beat(CMD_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    item_count = 0;

    while (item_count < ITEM_TARGET) begin
      // Each round starts once every beat is taken and every expected result has been seen.
      settle();
      case (round % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
        default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
      endcase
      case (round)
        0: len_pick = 9'd1;
        1: len_pick = 9'd0;
        3: len_pick = 9'd256;
        4: len_pick = 9'd511;
        default: begin
          roll = $urandom_range(9);
          if (roll == 0) len_pick = 9'd0;
          else if (roll == 1) len_pick = 9'd1;
          else if (roll == 2) len_pick = 9'd256;
          else if (roll == 3) len_pick = 9'($urandom_range(257, 511));
          else len_pick = 9'($urandom_range(2, 32));
        end
      endcase
      if (round < 5 || $urandom_range(9) < 7) set_key_len(len_pick);

      repeat ($urandom_range(0, 6))
        push_beat(CMD_KEY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      push_schedule();
      if (round == 4) begin
        // Receiver holds off while the sender keeps offering data, so the core backs up.
        repeat (40)
          push_beat(CMD_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        hold_req++;
      end
      repeat ($urandom_range(5, 40)) begin
        roll = $urandom_range(99);
        if (roll < 4)
          push_beat(CMD_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        else if (roll < 10)
          push_beat(CMD_KEY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        else if (roll < 12) push_schedule();
        else push_beat(CMD_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      round++;
    end

    settle();
    repeat (END_GAP) @(posedge clk);
    if (err_count == 0) begin
      $display("rc4_stream_cipher_core regression: pass");
    end else begin
      $display("rc4_stream_cipher_core regression: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("rc4_stream_cipher_core regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
